// ----- sv/kdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared widths, register indexes, reset values, key phase and value codes,
// and the structs passed between the scan logic, the key lanes and the merge.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    localparam int KEYS_DEFAULT = 3;

    localparam int INTERVAL_W = 8;
    localparam int COUNT_W    = 16;
    localparam int VAL_W      = 2;
    localparam int PHASE_W    = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LEVEL   = 2'd2;

    localparam logic [INTERVAL_W-1:0] SCAN_INTERVAL_RST = 8'd10;
    localparam logic [COUNT_W-1:0]    LONG_COUNT_RST    = 16'd200;
    localparam logic                  PRESS_LEVEL_RST   = 1'b0;

    // Key phases
    localparam logic [PHASE_W-1:0] PH_UP            = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PRESS_BOUNCE  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DOWN          = 2'd2;
    localparam logic [PHASE_W-1:0] PH_RELEASE_BOUNCE = 2'd3;

    // Key value codes
    localparam logic [VAL_W-1:0] VAL_NONE         = 2'd0;
    localparam logic [VAL_W-1:0] VAL_CLICK        = 2'd1;
    localparam logic [VAL_W-1:0] VAL_LONG_RELEASE = 2'd2;
    localparam logic [VAL_W-1:0] VAL_LONG_HELD    = 2'd3;

    // Common control fanned out to every lane
    typedef struct packed {
        logic               step;
        logic               press_level;
        logic [COUNT_W-1:0] long_count;
    } lane_ctrl_t;

    // What one lane found on this item
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             click;
        logic             long_hit;
    } lane_res_t;

endpackage

// ----- sv/kdlp_if.sv -----
// ----------------------------------------------------------------------------
// kdlp_if
// Valid/ready channels of the key debouncer: tick input, event output and
// configuration write.
// ----------------------------------------------------------------------------
interface kdlp_key_if
    import kdlp_pkg::*;
    #(parameter int NUM_KEYS = KEYS_DEFAULT)
    ();
    logic                valid;
    logic                ready;
    logic [NUM_KEYS-1:0] key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

interface kdlp_evt_if
    import kdlp_pkg::*;
    #(parameter int NUM_KEYS = KEYS_DEFAULT)
    ();
    logic                      valid;
    logic                      ready;
    logic                      scanned;
    logic [VAL_W*NUM_KEYS-1:0] key_values;
    logic [NUM_KEYS-1:0]       click_pulses;
    logic [NUM_KEYS-1:0]       long_pulses;

    modport source (output valid, output scanned, output key_values,
                    output click_pulses, output long_pulses, input ready);
    modport sink   (input valid, input scanned, input key_values,
                    input click_pulses, input long_pulses, output ready);
endinterface

interface kdlp_cfg_if
    import kdlp_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- sv/key_debounce_long_press_fsm.sv -----
// ----------------------------------------------------------------------------
// key_debounce_long_press_fsm
// Debounce NUM_KEYS keys on a millisecond tick and report clicks, long
// presses and the current key value codes, one event item per tick.
// ----------------------------------------------------------------------------
//
//   port     dir   payload                                        role
//   -------  ----  ---------------------------------------------  -----------
//   cfg      in    index, wdata                                   reg write
//   key_in   in    key_levels                                     ms tick
//   evt_out  out   scanned, key_values, click_pulses, long_pulses events
//
// One tick item is accepted per clock when evt_out keeps up; its event item
// appears in the output register on the next cycle, so throughput is one
// item per clock, set by the single-stage lane update feeding that register.
// key_in.ready drops only while the output register holds an item that
// evt_out has not taken; a stall on evt_out backs up directly to key_in.
// Reset clears the tick counter, puts every key in the up phase with value
// none, and loads scan_interval 10, long_count 200, press_level 0.
// cfg is always ready; writes to an unused index are dropped.
//
module key_debounce_long_press_fsm
    import kdlp_pkg::*;
#(
    parameter int NUM_KEYS = KEYS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    kdlp_cfg_if.sink    cfg,
    kdlp_key_if.sink    key_in,
    kdlp_evt_if.source  evt_out
);

    // Configuration registers
    logic [INTERVAL_W-1:0] scan_interval_reg;
    logic [COUNT_W-1:0]    long_count_reg;
    logic                  press_level_reg;

    logic       accept;
    logic       scan;
    logic       in_ready;
    lane_ctrl_t ctrl;
    lane_res_t  res [NUM_KEYS];

    // ------------------------------------------------------------------
    // Register writes: always take them, decode the index.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_interval_reg <= SCAN_INTERVAL_RST;
            long_count_reg    <= LONG_COUNT_RST;
            press_level_reg   <= PRESS_LEVEL_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SCAN_INTERVAL: scan_interval_reg <= cfg.wdata[INTERVAL_W-1:0];
                REG_LONG_COUNT:    long_count_reg    <= cfg.wdata[COUNT_W-1:0];
                REG_PRESS_LEVEL:   press_level_reg   <= cfg.wdata[0];
                default:
                begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input handshake: take a tick whenever the output register has room.
    // ------------------------------------------------------------------
    assign key_in.ready = in_ready;
    assign accept       = key_in.valid && in_ready;

    // Decide whether this tick scans the keys
    kdlp_scan_timer u_timer (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept),
        .scan_interval (scan_interval_reg),
        .scan          (scan)
    );

    // Lanes step only on accepted ticks that scan
    always_comb
    begin
        ctrl.step        = accept && scan;
        ctrl.press_level = press_level_reg;
        ctrl.long_count  = long_count_reg;
    end

    // ------------------------------------------------------------------
    // One debounce lane per key, all stepping on the same scan.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        kdlp_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .level (key_in.key_levels[k]),
            .res   (res[k])
        );
    end

    // Combine lane results and register the event item
    kdlp_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (accept),
        .scan     (scan),
        .res      (res),
        .evt_out  (evt_out),
        .in_ready (in_ready)
    );

endmodule

// ----- sv/kdlp_scan_timer.sv -----
// ----------------------------------------------------------------------------
// kdlp_scan_timer
// Millisecond tick counter; flags a scan once more than scan_interval ticks
// have passed since the last one.
// ----------------------------------------------------------------------------
module kdlp_scan_timer
    import kdlp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [INTERVAL_W-1:0] scan_interval,
    output logic                  scan
);

    logic [INTERVAL_W-1:0] elapsed_reg;
    logic [INTERVAL_W-1:0] elapsed_next;
    logic [INTERVAL_W:0]   tick_count;

    always_comb
    begin
        // compare one bit wider so an interval of 255 still scans
        tick_count   = {1'b0, elapsed_reg} + (INTERVAL_W+1)'(1);
        scan         = tick_count > {1'b0, scan_interval};
        elapsed_next = elapsed_reg;
        if (advance)
        begin
            elapsed_next = scan ? '0 : tick_count[INTERVAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
        end
    end

    a_scan_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && scan) |=> (elapsed_reg == '0))
        else $error("tick counter not restarted after a scan");

endmodule

// ----- sv/kdlp_lane.sv -----
// ----------------------------------------------------------------------------
// kdlp_lane
// Per-key debounce machine: up, press bounce, down, release bounce, with a
// saturating hold counter for long-press detection.
// ----------------------------------------------------------------------------
module kdlp_lane
    import kdlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctrl_t ctrl,
    input  logic       level,
    output lane_res_t  res
);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [COUNT_W-1:0] hold_reg;
    logic [COUNT_W-1:0] hold_next;
    logic [VAL_W-1:0]   value_reg;
    logic [VAL_W-1:0]   value_next;
    logic [COUNT_W-1:0] hold_inc;
    logic               pressed;
    logic               short_hold;
    logic               click;
    logic               long_hit;

    always_comb
    begin
        pressed    = (level == ctrl.press_level);
        // saturate at long_count
        hold_inc   = (hold_reg < ctrl.long_count) ? hold_reg + COUNT_W'(1) : hold_reg;
        short_hold = (hold_inc < ctrl.long_count);

        phase_next = phase_reg;
        hold_next  = hold_reg;
        value_next = value_reg;
        click      = 1'b0;
        long_hit   = 1'b0;

        if (ctrl.step)
        begin
            unique case (phase_reg)
                PH_UP:
                begin
                    if (pressed)
                    begin
                        phase_next = PH_PRESS_BOUNCE;
                    end
                    else
                    begin
                        value_next = VAL_NONE;
                    end
                end
                PH_PRESS_BOUNCE:
                begin
                    if (pressed)
                    begin
                        phase_next = PH_DOWN;
                        hold_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_UP;
                    end
                end
                PH_DOWN:
                begin
                    hold_next = hold_inc;
                    if (short_hold)
                    begin
                        if (!pressed)
                        begin
                            value_next = VAL_CLICK;
                            click      = 1'b1;
                            phase_next = PH_RELEASE_BOUNCE;
                        end
                    end
                    else if (!pressed)
                    begin
                        value_next = VAL_LONG_RELEASE;
                        phase_next = PH_RELEASE_BOUNCE;
                    end
                    else
                    begin
                        long_hit   = (value_reg != VAL_LONG_HELD);
                        value_next = VAL_LONG_HELD;
                    end
                end
                PH_RELEASE_BOUNCE:
                begin
                    // hold here while the key still reads pressed
                    if (!pressed)
                    begin
                        phase_next = PH_UP;
                        value_next = VAL_NONE;
                    end
                end
            endcase
        end

        res.value    = value_next;
        res.click    = click;
        res.long_hit = long_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_UP;
            hold_reg  <= '0;
            value_reg <= VAL_NONE;
        end
        else
        begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            value_reg <= value_next;
        end
    end

    a_release_value: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RELEASE_BOUNCE) |->
            ((value_reg == VAL_CLICK) || (value_reg == VAL_LONG_RELEASE)))
        else $error("release bounce without a click or long-release value");

endmodule

// ----- sv/kdlp_merge.sv -----
// ----------------------------------------------------------------------------
// kdlp_merge
// Gather the lane results into one event item and hold it in the output
// register until the sink takes it.
// ----------------------------------------------------------------------------
module kdlp_merge
    import kdlp_pkg::*;
#(
    parameter int NUM_KEYS = KEYS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               scan,
    input  lane_res_t          res [NUM_KEYS],
    kdlp_evt_if.source         evt_out,
    output logic               in_ready
);

    logic                      valid_reg;
    logic                      valid_next;
    logic                      scanned_reg;
    logic [VAL_W*NUM_KEYS-1:0] values_reg;
    logic [NUM_KEYS-1:0]       clicks_reg;
    logic [NUM_KEYS-1:0]       longs_reg;
    logic [VAL_W*NUM_KEYS-1:0] values_next;
    logic [NUM_KEYS-1:0]       clicks_next;
    logic [NUM_KEYS-1:0]       longs_next;

    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            values_next[k*VAL_W +: VAL_W] = res[k].value;
            clicks_next[k]                = res[k].click;
            longs_next[k]                 = res[k].long_hit;
        end
        in_ready   = !valid_reg || evt_out.ready;
        valid_next = advance || (valid_reg && !evt_out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            scanned_reg <= scan;
            values_reg  <= values_next;
            clicks_reg  <= clicks_next;
            longs_reg   <= longs_next;
        end
    end

    assign evt_out.valid        = valid_reg;
    assign evt_out.scanned      = scanned_reg;
    assign evt_out.key_values   = values_reg;
    assign evt_out.click_pulses = clicks_reg;
    assign evt_out.long_pulses  = longs_reg;

    a_item_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> valid_reg)
        else $error("accepted item did not reach the output register");

    a_pulses_need_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !scan) |=> ((clicks_reg == '0) && (longs_reg == '0)))
        else $error("event pulse on a tick without a scan");

endmodule
